[hw/rtl/aesc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aesc_pkg: shared definitions for the arithmetic expression syntax checker
// Parse phases, verdict codes, bracket stack sizing, keyword spelling and the
// control and status bundles between the checker and its bracket stack.
// ----------------------------------------------------------------------------
package aesc_pkg;

  localparam int MAX_NEST = 32;
  localparam int DEPTH_W  = $clog2(MAX_NEST + 1);
  localparam int ADDR_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [1:0] VERDICT_PENDING  = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
  localparam logic [1:0] VERDICT_REJECTED = 2'd2;

  localparam logic BR_PAREN  = 1'b0;
  localparam logic BR_SQUARE = 1'b1;

  localparam logic [1:0] KW_SIN = 2'd0;
  localparam logic [1:0] KW_COS = 2'd1;
  localparam logic [1:0] KW_TAN = 2'd2;
  localparam logic [1:0] KW_LOG = 2'd3;

  typedef enum logic [8:0] {
    PH_OPND_MINUS = 9'b000000001,
    PH_OPND       = 9'b000000010,
    PH_KEYWORD    = 9'b000000100,
    PH_SGROUP     = 9'b000001000,
    PH_INT        = 9'b000010000,
    PH_DOT        = 9'b000100000,
    PH_FRAC       = 9'b001000000,
    PH_AFTER      = 9'b010000000,
    PH_FAIL       = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic kind;
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic top_kind;
  } stk_stat_t;

  // Spelling of the keywords: sin( cos( tan( log(
  function automatic logic [7:0] kw_char(input logic [1:0] which, input logic [1:0] pos);
    logic [7:0] c;
    c = "(";
    case (which)
      KW_SIN: begin
        case (pos)
          2'd0:    c = "s";
          2'd1:    c = "i";
          2'd2:    c = "n";
          default: c = "(";
        endcase
      end
      KW_COS: begin
        case (pos)
          2'd0:    c = "c";
          2'd1:    c = "o";
          2'd2:    c = "s";
          default: c = "(";
        endcase
      end
      KW_TAN: begin
        case (pos)
          2'd0:    c = "t";
          2'd1:    c = "a";
          2'd2:    c = "n";
          default: c = "(";
        endcase
      end
      default: begin
        case (pos)
          2'd0:    c = "l";
          2'd1:    c = "o";
          2'd2:    c = "g";
          default: c = "(";
        endcase
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/aesc_stack.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aesc_stack: bracket kind stack
// Kinds live in a synchronous memory. The top is held in a register and the
// entry beneath it is read ahead every cycle, so a pop has its new top ready
// at the next edge.
// ----------------------------------------------------------------------------
module aesc_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  aesc_pkg::stk_cmd_t   cmd,
  output aesc_pkg::stk_stat_t  stat
);
  import aesc_pkg::*;

  logic               mem [MAX_NEST];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic [DEPTH_W-1:0] rd_ptr;
  logic [ADDR_W-1:0]  rd_addr;
  logic               top_kind;
  logic               below;

  always_comb begin
    depth_next = depth;
    if (cmd.clear) begin
      depth_next = '0;
    end else if (cmd.push) begin
      depth_next = depth + DEPTH_W'(1);
    end else if (cmd.pop) begin
      depth_next = depth - DEPTH_W'(1);
    end
  end

  // Prefetch the entry beneath the next top; it never aliases the write slot
  assign rd_ptr  = depth_next - DEPTH_W'(2);
  assign rd_addr = rd_ptr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth[ADDR_W-1:0]] <= cmd.kind;
    end
    below <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_kind <= cmd.kind;
    end else if (cmd.pop) begin
      top_kind <= below;
    end
  end

  assign stat.empty    = (depth == '0);
  assign stat.full     = (depth == DEPTH_W'(MAX_NEST));
  assign stat.top_kind = top_kind;

endmodule
`default_nettype wire

[hw/rtl/arithmetic_expression_syntax_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// arithmetic_expression_syntax_checker: streaming expression recogniser
// Checks a character stream against the expression grammar and gives a
// verdict on each end request.
// ----------------------------------------------------------------------------
// A new request is taken each cycle while the output register is free or
// being drained. A character request returns a pending verdict with the
// sticky error flag; an end request returns accepted or rejected and returns
// the checker to its start state. Open brackets are kept in a 32-entry stack
// memory; the top kind sits in a register and the entry beneath it is read
// ahead, so closers resolve in the same cycle. Opening a bracket beyond 32
// levels counts as a syntax error.
// ----------------------------------------------------------------------------
module arithmetic_expression_syntax_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] verdict,
  output logic       failed_so_far
);
  import aesc_pkg::*;

  phase_t     phase, phase_next;
  logic [1:0] kw_which, kw_which_next;
  logic [1:0] kw_pos, kw_pos_next;
  stk_cmd_t   cmd;
  stk_stat_t  stat;

  logic       accept;
  logic       is_digit;
  logic       kw_hit;
  logic [1:0] kw_idx;
  logic       want_open;
  logic       want_close;
  logic       br_kind;
  logic       after_factor;
  logic       ok;

  aesc_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_digit = ch inside {["0":"9"]};

  always_comb begin
    kw_hit = 1'b1;
    kw_idx = KW_SIN;
    case (ch)
      "s":     kw_idx = KW_SIN;
      "c":     kw_idx = KW_COS;
      "t":     kw_idx = KW_TAN;
      "l":     kw_idx = KW_LOG;
      default: kw_hit = 1'b0;
    endcase
  end

  assign ok = (phase == PH_INT || phase == PH_FRAC || phase == PH_AFTER) && stat.empty;

  always_comb begin
    phase_next    = phase;
    kw_which_next = kw_which;
    kw_pos_next   = kw_pos;
    cmd           = '0;
    want_open     = 1'b0;
    want_close    = 1'b0;
    br_kind       = BR_PAREN;
    after_factor  = 1'b0;

    if (accept && kind == KIND_END) begin
      phase_next    = PH_OPND_MINUS;
      kw_which_next = KW_SIN;
      kw_pos_next   = 2'd0;
      cmd.clear     = 1'b1;
    end else if (accept) begin
      case (phase)
        PH_OPND_MINUS, PH_OPND: begin
          if (phase == PH_OPND_MINUS && ch == "-") begin
            phase_next = PH_OPND;
          end else if (kw_hit) begin
            phase_next    = PH_KEYWORD;
            kw_which_next = kw_idx;
            kw_pos_next   = 2'd1;
          end else if (ch == "(") begin
            want_open = 1'b1;
          end else if (ch == "[") begin
            want_open = 1'b1;
            br_kind   = BR_SQUARE;
          end else if (is_digit) begin
            phase_next = PH_INT;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_KEYWORD: begin
          if (kw_pos == 2'd0 || ch != kw_char(kw_which, kw_pos)) begin
            phase_next = PH_FAIL;
          end else if (kw_pos == 2'd3) begin
            kw_pos_next = 2'd0;
            want_open   = 1'b1;
          end else begin
            kw_pos_next = kw_pos + 2'd1;
          end
        end
        PH_SGROUP: begin
          if (ch == "(") begin
            want_open = 1'b1;
          end else if (ch == "[") begin
            want_open = 1'b1;
            br_kind   = BR_SQUARE;
          end else if (is_digit) begin
            phase_next = PH_INT;
          end else begin
            phase_next = PH_FAIL;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            phase_next = PH_INT;
          end else if (ch == ".") begin
            phase_next = PH_DOT;
          end else begin
            after_factor = 1'b1;
          end
        end
        PH_DOT: begin
          phase_next = is_digit ? PH_FRAC : PH_FAIL;
        end
        PH_FRAC: begin
          if (is_digit) begin
            phase_next = PH_FRAC;
          end else begin
            after_factor = 1'b1;
          end
        end
        PH_AFTER: begin
          after_factor = 1'b1;
        end
        default: begin
          phase_next = PH_FAIL;
        end
      endcase

      if (after_factor) begin
        case (ch)
          "!":               phase_next = PH_AFTER;
          "^":               phase_next = PH_SGROUP;
          "+", "-", "*", "/": phase_next = PH_OPND_MINUS;
          ")": begin
            want_close = 1'b1;
            br_kind    = BR_PAREN;
          end
          "]": begin
            want_close = 1'b1;
            br_kind    = BR_SQUARE;
          end
          default:           phase_next = PH_FAIL;
        endcase
      end

      if (want_open) begin
        if (stat.full) begin
          phase_next = PH_FAIL;
        end else begin
          phase_next = PH_OPND_MINUS;
          cmd.push   = 1'b1;
          cmd.kind   = br_kind;
        end
      end

      if (want_close) begin
        if (stat.empty || stat.top_kind != br_kind) begin
          phase_next = PH_FAIL;
        end else begin
          phase_next = PH_AFTER;
          cmd.pop    = 1'b1;
        end
      end

      if (phase_next == PH_FAIL) begin
        kw_pos_next = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPND_MINUS;
      kw_which <= KW_SIN;
      kw_pos   <= 2'd0;
    end else begin
      phase    <= phase_next;
      kw_which <= kw_which_next;
      kw_pos   <= kw_pos_next;
    end
  end

  // Hold the result until taken; load a fresh one on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (kind == KIND_END) begin
        verdict       <= ok ? VERDICT_ACCEPTED : VERDICT_REJECTED;
        failed_so_far <= !ok;
      end else begin
        verdict       <= VERDICT_PENDING;
        failed_so_far <= (phase_next == PH_FAIL);
      end
    end
  end

endmodule
`default_nettype wire
